### src/time_sliced_round_robin_path_picker_macros.svh
// ----------------------------------------------------------------------------
// Round-robin path picker assertion macros
// Implication and next-cycle implication checks on a clocked, reset-gated
// property.
// ----------------------------------------------------------------------------
`ifndef TIME_SLICED_ROUND_ROBIN_PATH_PICKER_MACROS_SVH
`define TIME_SLICED_ROUND_ROBIN_PATH_PICKER_MACROS_SVH

// same-cycle implication
`define TSRR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsrr assertion failed");

// next-cycle implication
`define TSRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsrr assertion failed");

`endif

### src/tsrr_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin path picker package
// Field widths and fixed constants shared by the interfaces and the picker.
// ----------------------------------------------------------------------------
package tsrr_pkg;

    localparam int MASK_W   = 16;
    localparam int TIME_W   = 48;
    localparam int PERIOD_W = 32;
    localparam int PATH_W   = 4;
    localparam int CNT_W    = 5;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd20000;

    localparam logic CMD_INIT = 1'b0;
    localparam logic CMD_PICK = 1'b1;

endpackage

### src/tsrr_if.sv
// ----------------------------------------------------------------------------
// Round-robin path picker channels
// Request channel (command, eligibility mask, time) and result channel.
// ----------------------------------------------------------------------------
interface tsrr_req_if import tsrr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [MASK_W-1:0] eligible_mask;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output cmd, output eligible_mask, output now_ms,
                    input ready);
    modport sink   (input valid, input cmd, input eligible_mask, input now_ms,
                    output ready);
endinterface

interface tsrr_res_if import tsrr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              ok;
    logic [PATH_W-1:0] path_index;
    logic              switched;

    modport source (output valid, output ok, output path_index, output switched,
                    input ready);
    modport sink   (input valid, input ok, input path_index, input switched,
                    output ready);
endinterface

### src/time_sliced_round_robin_path_picker.sv
// Pick: once the request is taken, the picker counts the eligible paths one mask
// bit at a time (MAX_PATHS capped at 16), reduces the advanced rank modulo that
// count by repeated subtraction when the period is due, then scans the mask bit
// by bit to locate the ranked path. Init gives no result.
// One request at a time; the next is taken once the result has been accepted.
// Synchronous reset clears rank, switch time and control; period resets to 20000.
// ----------------------------------------------------------------------------
// Time-sliced round-robin path picker
// Counts eligible paths, advances the rank when a period has elapsed by a
// repeated-subtraction modulo, then scans the mask for the ranked eligible path.
// ----------------------------------------------------------------------------
module time_sliced_round_robin_path_picker import tsrr_pkg::*; #(
    parameter int MAX_PATHS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [PERIOD_W-1:0] i_cfg_wdata,
    tsrr_req_if.sink            i_req,
    tsrr_res_if.source          o_res
);

    localparam int LIM = (MAX_PATHS > MASK_W) ? MASK_W : MAX_PATHS;
    localparam logic [PATH_W-1:0] LAST_IDX = PATH_W'(LIM - 1);
    localparam logic [MASK_W:0]   LIM_ONE  = (MASK_W + 1)'(1) << LIM;
    localparam logic [MASK_W-1:0] LIM_MASK = MASK_W'(LIM_ONE - (MASK_W + 1)'(1));

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_MOD,
        S_SEL,
        S_OUT
    } t_state;

    t_state              r_state, n_state;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic [PATH_W-1:0]   r_rank, n_rank;
    logic [TIME_W-1:0]   r_last, n_last;
    logic [MASK_W-1:0]   r_mask, n_mask;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [PATH_W-1:0]   r_idx, n_idx;
    logic [PATH_W-1:0]   r_pos, n_pos;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CNT_W-1:0]    r_rem, n_rem;
    logic                r_ok, n_ok;
    logic [PATH_W-1:0]   r_path, n_path;
    logic                r_sw, n_sw;

    logic [TIME_W-1:0]   elapsed;
    logic                due;
    logic [CNT_W-1:0]    cnt_inc;

    assign elapsed = r_now - r_last;
    assign due     = elapsed >= {{(TIME_W - PERIOD_W){1'b0}}, r_period};
    assign cnt_inc = r_cnt + CNT_W'(r_mask[r_idx]);

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_res.valid      = (r_state == S_OUT);
    assign o_res.ok         = r_ok;
    assign o_res.path_index = r_path;
    assign o_res.switched   = r_sw;

    always_comb begin
        n_state  = r_state;
        n_period = i_cfg_we ? i_cfg_wdata : r_period;
        n_rank   = r_rank;
        n_last   = r_last;
        n_mask   = r_mask;
        n_now    = r_now;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_ok     = r_ok;
        n_path   = r_path;
        n_sw     = r_sw;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.cmd == CMD_INIT) begin
                        n_rank = '0;
                        n_last = i_req.now_ms;
                    end else begin
                        n_mask  = i_req.eligible_mask & LIM_MASK;
                        n_now   = i_req.now_ms;
                        n_idx   = '0;
                        n_cnt   = '0;
                        n_state = S_COUNT;
                    end
                end
            end
            S_COUNT: begin
                n_cnt = cnt_inc;
                if (r_idx == LAST_IDX) begin
                    n_idx = '0;
                    n_pos = '0;
                    if (cnt_inc == '0) begin
                        n_ok    = 1'b0;
                        n_path  = '0;
                        n_sw    = 1'b0;
                        n_state = S_OUT;
                    end else if (due) begin
                        n_rem   = CNT_W'(r_rank) + CNT_W'(1);
                        n_state = S_MOD;
                    end else begin
                        n_sw    = 1'b0;
                        n_state = S_SEL;
                    end
                end else begin
                    n_idx = r_idx + PATH_W'(1);
                end
            end
            S_MOD: begin
                if (r_rem >= r_cnt) begin
                    n_rem = r_rem - r_cnt;
                end else begin
                    n_rank  = r_rem[PATH_W-1:0];
                    n_last  = r_now;
                    n_sw    = 1'b1;
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                if (r_mask[r_idx] && (r_pos == r_rank)) begin
                    n_ok    = 1'b1;
                    n_path  = r_idx;
                    n_state = S_OUT;
                end else begin
                    if (r_mask[r_idx]) begin
                        n_pos = r_pos + PATH_W'(1);
                    end
                    if (r_idx == LAST_IDX) begin
                        n_ok    = 1'b0;
                        n_path  = '0;
                        n_state = S_OUT;
                    end else begin
                        n_idx = r_idx + PATH_W'(1);
                    end
                end
            end
            S_OUT: begin
                if (o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_period <= PERIOD_RESET;
            r_rank   <= '0;
            r_last   <= '0;
        end else begin
            r_state  <= n_state;
            r_period <= n_period;
            r_rank   <= n_rank;
            r_last   <= n_last;
        end
        r_mask <= n_mask;
        r_now  <= n_now;
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_ok   <= n_ok;
        r_path <= n_path;
        r_sw   <= n_sw;
    end

endmodule

### src/tsrr_checker.sv
// ----------------------------------------------------------------------------
// Round-robin path picker checker
// Port-level checks on the request and result channels, bound to the picker.
// ----------------------------------------------------------------------------
`include "time_sliced_round_robin_path_picker_macros.svh"

module tsrr_checker import tsrr_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_ready,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic              i_res_ok,
    input logic [PATH_W-1:0] i_res_path_index,
    input logic              i_res_switched
);

    logic              res_stall;
    logic [PATH_W+1:0] res_fields;

    assign res_stall  = i_res_valid && !i_res_ready;
    assign res_fields = {i_res_ok, i_res_path_index, i_res_switched};

    `TSRR_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, res_stall, i_res_valid)
    `TSRR_ASSERT_NEXT(a_res_stable, i_clk, i_rst_n, res_stall, $stable(res_fields))
    `TSRR_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, i_res_valid && !i_res_ok, i_res_path_index == '0)
    `TSRR_ASSERT_IMPL(a_one_at_a_time, i_clk, i_rst_n, i_res_valid, !i_req_ready)
    `TSRR_ASSERT_IMPL(a_switch_picks, i_clk, i_rst_n, i_res_valid && i_res_switched, i_res_ok)

endmodule

bind time_sliced_round_robin_path_picker tsrr_checker u_tsrr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_ready      (i_req.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_ok         (o_res.ok),
    .i_res_path_index (o_res.path_index),
    .i_res_switched   (o_res.switched)
);

### tb/tsrr_pick_checker.sv
// ----------------------------------------------------------------------------
// Round-robin path picker checker
// Watches the request, result and period write ports, predicts each pick from
// its own copy of rank, switch time and period, and compares every accepted
// result field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tsrr_pick_checker import tsrr_pkg::*; #(
    parameter int MAX_PATHS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [PERIOD_W-1:0] i_cfg_wdata,
    tsrr_req_if                 i_req,
    tsrr_res_if                 i_res,
    output int                  o_errors,
    output int                  o_pending
);

    localparam int SCAN_W = (MAX_PATHS < MASK_W) ? MAX_PATHS : MASK_W;

    typedef struct packed {
        logic              ok;
        logic [PATH_W-1:0] path_index;
        logic              switched;
    } t_pick_res;

    logic [PATH_W-1:0]   rank;
    logic [TIME_W-1:0]   last_switch_ms;
    logic [PERIOD_W-1:0] period_ms;
    t_pick_res           expected_picks[$];
    int                  errors = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        if (errors <= 100)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic t_pick_res predict_pick(input logic [MASK_W-1:0] mask,
                                               input logic [TIME_W-1:0] now);
        t_pick_res         res;
        int                count;
        int                pos;
        logic [TIME_W-1:0] elapsed;
        res   = '0;
        count = 0;
        pos   = 0;
        for (int i = 0; i < SCAN_W; i++)
            if (mask[i]) count++;
        if (count == 0)
            return res;
        elapsed = now - last_switch_ms;
        if (elapsed >= TIME_W'(period_ms)) begin
            rank           = PATH_W'((int'(rank) + 1) % count);
            last_switch_ms = now;
            res.switched   = 1'b1;
        end
        for (int i = 0; i < SCAN_W; i++) begin
            if (mask[i]) begin
                if (pos == int'(rank)) begin
                    res.ok         = 1'b1;
                    res.path_index = PATH_W'(i);
                    return res;
                end
                pos++;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pick_res got;
        t_pick_res want;
        if (!i_rst_n) begin
            rank           = '0;
            last_switch_ms = '0;
            period_ms      = PERIOD_RESET;
            expected_picks.delete();
        end else begin
            if (i_cfg_we)
                period_ms = i_cfg_wdata;
            if (i_req.valid && i_req.ready) begin
                if (i_req.cmd == CMD_INIT) begin
                    rank           = '0;
                    last_switch_ms = i_req.now_ms;
                end else begin
                    expected_picks.push_back(predict_pick(i_req.eligible_mask, i_req.now_ms));
                end
            end
            if (i_res.valid && i_res.ready) begin
                got.ok         = i_res.ok;
                got.path_index = i_res.path_index;
                got.switched   = i_res.switched;
                if (expected_picks.size() == 0) begin
                    report_mismatch("result with no request waiting", got, 0);
                end else begin
                    want = expected_picks.pop_front();
                    if (got.ok !== want.ok)
                        report_mismatch("ok", got.ok, want.ok);
                    if (got.path_index !== want.path_index)
                        report_mismatch("path_index", got.path_index, want.path_index);
                    if (got.switched !== want.switched)
                        report_mismatch("switched", got.switched, want.switched);
                end
            end
        end
        o_pending <= expected_picks.size();
        o_errors  <= errors;
    end

endmodule

### tb/time_sliced_round_robin_path_picker_test.sv
// ----------------------------------------------------------------------------
// Round-robin path picker testbench
// Drives directed and random pick and init requests under several switch
// periods, with random idling on both channels and one long result stall,
// and gives the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module time_sliced_round_robin_path_picker_test;
    import tsrr_pkg::*;

    localparam int MAX_PATHS   = 16;
    localparam int DRAIN_WAIT  = 60;
    localparam int PHASE_ITEMS = 110;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [PERIOD_W-1:0] cfg_wdata;
    int                  errors;
    int                  pending;
    logic                idling;
    logic [TIME_W-1:0]   clock_ms;
    logic [MASK_W-1:0]   last_mask;
    logic [PERIOD_W-1:0] cur_period;
    logic [PERIOD_W-1:0] phase_periods[5];

    tsrr_req_if req_ch();
    tsrr_res_if res_ch();

    time_sliced_round_robin_path_picker #(.MAX_PATHS(MAX_PATHS)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_res       (res_ch)
    );

    tsrr_pick_checker #(.MAX_PATHS(MAX_PATHS)) u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .i_res       (res_ch),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #3000000;
        $display("FAIL");
        $finish;
    end

    function automatic int draw_gap();
        return idling ? $urandom_range(0, 17) : 0;
    endfunction

    task automatic send_request(input logic cmd, input logic [MASK_W-1:0] mask,
                                input logic [TIME_W-1:0] now);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= cmd;
        req_ch.eligible_mask <= mask;
        req_ch.now_ms        <= now;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        cur_period = value;
    endtask

    task automatic random_request();
        int                r;
        logic [TIME_W-1:0] adv;
        logic [MASK_W-1:0] mask;
        logic              cmd;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            clock_ms = TIME_W'({$urandom, $urandom});
        end else begin
            if (r < 45)
                adv = (cur_period > 1) ? TIME_W'($urandom_range(0, cur_period - 1)) : '0;
            else if (r < 80)
                adv = TIME_W'(cur_period) - 1 + TIME_W'($urandom_range(0, 2));
            else
                adv = TIME_W'(cur_period) * TIME_W'($urandom_range(1, 3))
                    + TIME_W'($urandom_range(0, 99));
            clock_ms = clock_ms + adv;
        end
        r = $urandom_range(0, 99);
        if (r < 10)
            mask = '0;
        else if (r < 20)
            mask = '1;
        else if (r < 35)
            mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
        else if (r < 60)
            mask = last_mask & MASK_W'($urandom);
        else
            mask = MASK_W'($urandom);
        cmd = ($urandom_range(0, 19) == 0) ? CMD_INIT : CMD_PICK;
        if (mask != '0)
            last_mask = mask;
        else if ($urandom_range(0, 3) == 0)
            last_mask = '1;
        send_request(cmd, mask, clock_ms);
    endtask

    initial begin
        int gap;
        int res_taken;
        bit held;
        res_ch.ready <= 1'b0;
        res_taken = 0;
        held      = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            gap = draw_gap();
            if (!held && res_taken == 150) begin
                held = 1'b1;
                gap  = 400;
            end
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            res_taken++;
        end
    end

    initial begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.cmd           <= CMD_PICK;
        req_ch.eligible_mask <= '0;
        req_ch.now_ms        <= '0;
        idling     = 1'b0;
        clock_ms   = '0;
        last_mask  = '1;
        cur_period = PERIOD_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_request(CMD_PICK, 16'h0000, 48'd0);
        send_request(CMD_PICK, 16'hFFFF, 48'd0);
        send_request(CMD_PICK, 16'h8000, 48'd19999);
        send_request(CMD_PICK, 16'hFFFF, 48'd20000);
        send_request(CMD_PICK, 16'hAAAA, 48'd40000);
        send_request(CMD_INIT, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        send_request(CMD_PICK, 16'h0001, 48'd19998);
        send_request(CMD_PICK, 16'h0001, 48'd19999);
        send_request(CMD_PICK, 16'h8000, 48'd5);

        write_period(32'd1);
        for (int k = 1; k <= 8; k++)
            send_request(CMD_PICK, 16'hFFFF, TIME_W'(100 + k));
        // rank now lies past the shrunken eligible count
        send_request(CMD_PICK, 16'h0700, 48'd108);
        send_request(CMD_PICK, 16'h0700, 48'd109);

        write_period(32'hFFFF_FFFF);
        send_request(CMD_INIT, 16'h0000, 48'd0);
        send_request(CMD_PICK, 16'hFFFF, 48'hFFFF_FFFE);
        send_request(CMD_PICK, 16'hFFFF, 48'hFFFF_FFFF);
        send_request(CMD_PICK, 16'hFFFF, 48'hFFFF_FFFF_FFFF);

        phase_periods[0] = PERIOD_W'($urandom_range(2, 40));
        phase_periods[1] = PERIOD_RESET;
        phase_periods[2] = 32'hFFFF_FFFF;
        phase_periods[3] = 32'd1;
        phase_periods[4] = PERIOD_W'($urandom);
        for (int p = 0; p < 5; p++) begin
            write_period(phase_periods[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    idling = ($urandom_range(0, 3) != 0);
                random_request();
            end
        end

        wait_drained();
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/tsrr_pkg.sv
src/tsrr_if.sv
src/time_sliced_round_robin_path_picker.sv
src/tsrr_checker.sv
tb/tsrr_pick_checker.sv
tb/time_sliced_round_robin_path_picker_test.sv
